// ===== rtl/core/obdpd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// obdpd_pkg
// Shared types and constants for the mode 01 PID reply decoder.
// ---------------------------------------------------------------------------
package obdpd_pkg;

    localparam int unsigned MaxDigits   = 8;
    localparam int unsigned MinDigits   = 6;
    localparam int unsigned StoreWidth  = 4 * MaxDigits;
    localparam int unsigned CountWidth  = 4;
    localparam int unsigned ValueWidth  = 17;
    localparam int unsigned TdataWidth  = 32;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_INVALID     = 2'd1,
        STATUS_UNSUPPORTED = 2'd2
    } status_t;

    localparam logic [7:0] PidRpm      = 8'h0C;
    localparam logic [7:0] PidSpeed    = 8'h0D;
    localparam logic [7:0] PidCoolant  = 8'h05;
    localparam logic [7:0] PidThrottle = 8'h11;
    localparam logic [7:0] PidMaf      = 8'h10;
    localparam logic [7:0] PidLoad     = 8'h43;

    localparam logic [3:0] ModeHigh    = 4'h4;
    localparam logic [3:0] ModeLow     = 4'h1;

    typedef struct packed {
        logic [StoreWidth-1:0] digits;
        logic [CountWidth-1:0] count;
    } reply_t;

    typedef struct packed {
        status_t                status;
        logic [7:0]             pid;
        logic [ValueWidth-1:0]  value;
    } result_t;

endpackage : obdpd_pkg
`default_nettype wire

// ===== rtl/core/obdpd_decode.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// obdpd_decode
// Turns the collected hex digits of one reply into status, PID and value.
// ---------------------------------------------------------------------------
module obdpd_decode
(
    input  var obdpd_pkg::reply_t  reply,
    output var obdpd_pkg::result_t result
);
    import obdpd_pkg::*;

    logic [7:0]  pid_byte;
    logic [7:0]  a_byte;
    logic [7:0]  b_byte;
    logic        header_ok;
    logic        full_data;
    logic [14:0] pct_prod;
    logic [15:0] pct_sum;
    logic [7:0]  pct_quot;

    assign pid_byte  = reply.digits[23:16];
    assign a_byte    = reply.digits[15:8];
    assign b_byte    = reply.digits[7:0];
    assign header_ok = (reply.count >= CountWidth'(MinDigits))
                       && (reply.digits[31:28] == ModeHigh)
                       && (reply.digits[27:24] == ModeLow);
    assign full_data = (reply.count >= CountWidth'(MaxDigits));

    // floor(x / 255) for x below 65535 is (x + 1 + (x >> 8)) >> 8.
    assign pct_prod = 15'(a_byte) * 15'd100;
    assign pct_sum  = 16'(pct_prod) + 16'd1 + 16'(pct_prod[14:8]);
    assign pct_quot = pct_sum[15:8];

    always_comb
    begin
        result.status = STATUS_OK;
        result.pid    = 8'd0;
        result.value  = '0;
        if (!header_ok)
        begin
            result.status = STATUS_INVALID;
        end
        else
        begin
            result.pid = pid_byte;
            unique case (pid_byte)
                PidRpm:
                begin
                    if (full_data)
                        result.value = ValueWidth'({a_byte, b_byte[7:2]});
                    else
                        result.status = STATUS_UNSUPPORTED;
                end
                PidSpeed:
                    result.value = ValueWidth'(a_byte);
                PidCoolant:
                    result.value = ValueWidth'(a_byte) - ValueWidth'(40);
                PidThrottle, PidLoad:
                    result.value = ValueWidth'(pct_quot);
                PidMaf:
                begin
                    if (full_data)
                        result.value = ValueWidth'({a_byte, b_byte});
                    else
                        result.status = STATUS_UNSUPPORTED;
                end
                default:
                    result.status = STATUS_UNSUPPORTED;
            endcase
        end
    end

endmodule : obdpd_decode
`default_nettype wire

// ===== rtl/core/obd_pid_response_decoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// obd_pid_response_decoder
// Collects the hex digits of a mode 01 reply and decodes the PID value.
// ---------------------------------------------------------------------------
// One character word is taken per clock cycle while s_tready is high. Hex digits
// are collected (the first eight are kept), other characters are dropped, and a
// zero byte ends the reply until the word with tlast. That word produces one
// result word, which is registered in the cycle after; the state update and
// decode sit between the digit registers and the output register, so throughput
// is one word per cycle whenever the output side takes results.
// ---------------------------------------------------------------------------
module obd_pid_response_decoder
(
    input  var logic                               clk,
    input  var logic                               rst_n,
    input  var logic                               s_tvalid,
    output var logic                               s_tready,
    input  var logic [7:0]                         s_tdata,  // [7:0] char_in
    input  var logic                               s_tlast,  // last_char
    output var logic                               m_tvalid,
    input  var logic                               m_tready,
    // [1:0] status, [9:2] pid, [26:10] value, [31:27] zero
    output var logic [obdpd_pkg::TdataWidth-1:0]   m_tdata
);
    import obdpd_pkg::*;

    logic [StoreWidth-1:0] digits_reg, digits_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  term_reg, term_next;
    logic                  valid_reg, valid_next;
    result_t               result_reg, result_next;

    logic                  accept;
    logic                  is_hex;
    logic [3:0]            nibble;
    logic                  term_upd;
    reply_t                reply;
    result_t               decoded;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        is_hex = 1'b1;
        nibble = 4'd0;
        if (s_tdata >= "0" && s_tdata <= "9")
            nibble = 4'(s_tdata - "0");
        else if (s_tdata >= "A" && s_tdata <= "F")
            nibble = 4'(s_tdata - "A" + 8'd10);
        else if (s_tdata >= "a" && s_tdata <= "f")
            nibble = 4'(s_tdata - "a" + 8'd10);
        else
            is_hex = 1'b0;
    end

    // Digits after the word that fills the store, or after a zero byte, are lost.
    always_comb
    begin
        reply.digits = digits_reg;
        reply.count  = count_reg;
        term_upd     = term_reg;
        if (!term_reg)
        begin
            if (s_tdata == 8'd0)
            begin
                term_upd = 1'b1;
            end
            else if (is_hex && count_reg < CountWidth'(MaxDigits))
            begin
                reply.digits[StoreWidth-1 - 4*count_reg[2:0] -: 4] = nibble;
                reply.count = count_reg + CountWidth'(1);
            end
        end
    end

    obdpd_decode u_decode
    (
        .reply  (reply),
        .result (decoded)
    );

    always_comb
    begin
        digits_next = digits_reg;
        count_next  = count_reg;
        term_next   = term_reg;
        valid_next  = valid_reg && !m_tready;
        result_next = result_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                digits_next = '0;
                count_next  = '0;
                term_next   = 1'b0;
                valid_next  = 1'b1;
                result_next = decoded;
            end
            else
            begin
                digits_next = reply.digits;
                count_next  = reply.count;
                term_next   = term_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= '0;
            count_reg  <= '0;
            term_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            digits_reg <= digits_next;
            count_reg  <= count_next;
            term_reg   <= term_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, result_reg.value, result_reg.pid, result_reg.status};

endmodule : obd_pid_response_decoder
`default_nettype wire
